### rtl/lrmd_pkg.sv
// Shared constants and types for the linear range map with deadband.
package lrmd_pkg;

    localparam int TGT_W      = 16;
    localparam int DZ_W       = 15;
    localparam int Q_W        = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE   = 3'd4;

    typedef struct packed {
        logic valid;
        logic neg;
        logic dead;
    } lrmd_tag_t;

endpackage

### rtl/lrmd_div_step.sv
// One restoring-division stage: retires one quotient bit per word.
module lrmd_div_step #(
    parameter int REM_W = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic [REM_W-1:0]          divisor,
    input  logic [REM_W-1:0]          rem_i,
    input  logic [lrmd_pkg::Q_W-1:0]  word_i,
    input  lrmd_pkg::lrmd_tag_t       tag_i,
    output logic [REM_W-1:0]          rem_o,
    output logic [lrmd_pkg::Q_W-1:0]  word_o,
    output lrmd_pkg::lrmd_tag_t       tag_o
);
    import lrmd_pkg::*;

    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;
    logic             fits;
    logic [REM_W-1:0] rem_next;
    logic [Q_W-1:0]   word_next;
    logic [REM_W-1:0] rem_reg;
    logic [Q_W-1:0]   word_reg;
    logic             valid_reg;
    logic             neg_reg;
    logic             dead_reg;

    // word shifts dividend bits out at the top and quotient bits in at the bottom
    always_comb begin
        trial     = {rem_i, word_i[Q_W-1]};
        diff      = trial - {1'b0, divisor};
        fits      = (trial >= {1'b0, divisor});
        rem_next  = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
        word_next = {word_i[Q_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= tag_i.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            word_reg <= word_next;
            neg_reg  <= tag_i.neg;
            dead_reg <= tag_i.dead;
        end
    end

    assign rem_o  = rem_reg;
    assign word_o = word_reg;
    assign tag_o  = {valid_reg, neg_reg, dead_reg};

endmodule

### rtl/linear_range_map_deadband_unit.sv
// Linear range map with clamp, deadband and round-half-away rounding.
//
// Input channel s_*: one raw sample word per handshake (s_valid/s_ready).
// Output channel m_*: one mapped word per input word, in order.
// Config port cfg_*: write-only, cfg_wr_en with cfg_index selects
// source_min, source_max, target_low, target_high, dead_zone; write only
// while no word is in flight.
// Pipeline: a word accepted on s_* passes six front stages, sixteen divider
// stages and an output register before it is presented on m_*.
// Throughput: one word per cycle while the output is not stalled; the divider
// retires one quotient bit per stage over sixteen pipelined stages.
// Reset: valid bits clear, s_ready rises, registers load their defaults
// (source 0..max, target -32768..32767, no deadband).
// Stall: when the output holds a word and m_ready is low, the word leaving the
// pipeline is caught in a skid register; on the next cycle s_ready drops and
// the whole pipeline holds until the output drains.
module linear_range_map_deadband_unit #(
    parameter int SOURCE_BITS = 11
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [SOURCE_BITS-1:0]                 s_raw_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [lrmd_pkg::TGT_W-1:0]      m_mapped_value,
    input  logic                                   cfg_wr_en,
    input  logic [lrmd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lrmd_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import lrmd_pkg::*;

    localparam int DEN_W  = SOURCE_BITS;
    localparam int PROD_W = DEN_W + 18;
    localparam int MAG_W  = DEN_W + DZ_W;
    localparam int NUM_W  = DEN_W + 17;
    localparam int REM_W  = DEN_W + 1;

    // configuration
    logic [DEN_W-1:0]        src_min_reg;
    logic [DEN_W-1:0]        src_max_reg;
    logic signed [TGT_W-1:0] tgt_low_reg;
    logic signed [TGT_W-1:0] tgt_high_reg;
    logic [DZ_W-1:0]         dead_zone_reg;

    // values derived from configuration
    logic [DEN_W-1:0]        lo_next;
    logic [DEN_W-1:0]        hi_next;
    logic [DEN_W-1:0]        lo_reg;
    logic [DEN_W-1:0]        hi_reg;
    logic [DEN_W-1:0]        den_reg;
    logic signed [TGT_W:0]   span_reg;
    logic                    same_reg;
    logic signed [PROD_W-1:0] ptl_next;
    logic signed [PROD_W-1:0] ptl_reg;
    logic [MAG_W-1:0]        dzden_next;
    logic [MAG_W-1:0]        dzden_reg;

    // pipeline
    logic                    en;
    logic                    v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [DEN_W-1:0]        raw0_reg;
    logic [DEN_W-1:0]        clamp1;
    logic [DEN_W-1:0]        dc1_reg;
    logic signed [PROD_W-1:0] p2_next;
    logic signed [PROD_W-1:0] p2_reg;
    logic signed [PROD_W-1:0] num_reg;
    logic signed [PROD_W-1:0] mag_full;
    logic [MAG_W-1:0]        mag4_reg;
    logic                    neg4_reg;
    logic [NUM_W-1:0]        n5_reg;
    logic                    neg5_reg;
    logic                    dead5_reg;

    logic [REM_W-1:0]        divisor;
    logic [REM_W-1:0]        rem_w  [Q_W+1];
    logic [Q_W-1:0]          word_w [Q_W+1];
    lrmd_tag_t               tag_w  [Q_W+1];

    logic signed [TGT_W-1:0] res;
    logic                    m_valid_reg;
    logic signed [TGT_W-1:0] m_data_reg;
    logic                    skid_v_reg;
    logic signed [TGT_W-1:0] skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_min_reg   <= '0;
            src_max_reg   <= '1;
            tgt_low_reg   <= 16'sh8000;
            tgt_high_reg  <= 16'sh7FFF;
            dead_zone_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SOURCE_MIN:  src_min_reg   <= cfg_data[DEN_W-1:0];
                CFG_SOURCE_MAX:  src_max_reg   <= cfg_data[DEN_W-1:0];
                CFG_TARGET_LOW:  tgt_low_reg   <= $signed(cfg_data[TGT_W-1:0]);
                CFG_TARGET_HIGH: tgt_high_reg  <= $signed(cfg_data[TGT_W-1:0]);
                CFG_DEAD_ZONE:   dead_zone_reg <= cfg_data[DZ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (src_min_reg > src_max_reg) begin
            lo_next = src_max_reg;
            hi_next = src_min_reg;
        end else begin
            lo_next = src_min_reg;
            hi_next = src_max_reg;
        end
        ptl_next   = tgt_low_reg * $signed({1'b0, den_reg});
        dzden_next = dead_zone_reg * den_reg;
    end

    always_ff @(posedge aclk) begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        den_reg   <= hi_next - lo_next;
        span_reg  <= {tgt_high_reg[TGT_W-1], tgt_high_reg}
                   - {tgt_low_reg[TGT_W-1], tgt_low_reg};
        same_reg  <= (src_min_reg == src_max_reg);
        ptl_reg   <= ptl_next;
        dzden_reg <= dzden_next;
    end

    assign en      = !skid_v_reg;
    assign s_ready = en;

    always_comb begin
        if (raw0_reg < lo_reg) begin
            clamp1 = lo_reg;
        end else if (raw0_reg > hi_reg) begin
            clamp1 = hi_reg;
        end else begin
            clamp1 = raw0_reg;
        end
        p2_next  = $signed({1'b0, dc1_reg}) * span_reg;
        mag_full = num_reg[PROD_W-1] ? -num_reg : num_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            raw0_reg  <= s_raw_value;
            dc1_reg   <= clamp1 - lo_reg;
            p2_reg    <= p2_next;
            num_reg   <= ptl_reg + p2_reg;
            neg4_reg  <= num_reg[PROD_W-1];
            mag4_reg  <= mag_full[MAG_W-1:0];
            neg5_reg  <= neg4_reg;
            dead5_reg <= (mag4_reg < dzden_reg);
            // 2*mag + den over 2*den gives round-half-away on the magnitude
            n5_reg    <= {1'b0, mag4_reg, 1'b0} + NUM_W'(den_reg);
        end
    end

    assign divisor   = {den_reg, 1'b0};
    assign rem_w[0]  = n5_reg[NUM_W-1:Q_W];
    assign word_w[0] = n5_reg[Q_W-1:0];
    assign tag_w[0]  = {v5_reg, neg5_reg, dead5_reg};

    for (genvar i = 0; i < Q_W; i++) begin : g_div
        lrmd_div_step #(
            .REM_W (REM_W)
        ) u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .divisor (divisor),
            .rem_i   (rem_w[i]),
            .word_i  (word_w[i]),
            .tag_i   (tag_w[i]),
            .rem_o   (rem_w[i+1]),
            .word_o  (word_w[i+1]),
            .tag_o   (tag_w[i+1])
        );
    end

    always_comb begin
        if (same_reg) begin
            res = tgt_low_reg;
        end else if (tag_w[Q_W].dead) begin
            res = '0;
        end else if (tag_w[Q_W].neg) begin
            res = -$signed(word_w[Q_W]);
        end else begin
            res = $signed(word_w[Q_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            skid_v_reg  <= 1'b0;
        end else if (en) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_reg <= tag_w[Q_W].valid;
            end else if (tag_w[Q_W].valid) begin
                skid_v_reg <= 1'b1;
            end
        end else if (m_ready) begin
            skid_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!m_valid_reg || m_ready) begin
                m_data_reg <= res;
            end else begin
                skid_data_reg <= res;
            end
        end else if (m_ready) begin
            m_data_reg <= skid_data_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_mapped_value = m_data_reg;

endmodule

### rtl/lrmd_checker.sv
// Port-level checks for the range map unit, bound to the top level.
module lrmd_props (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [lrmd_pkg::TGT_W-1:0]  m_mapped_value
);
    import lrmd_pkg::*;

    // reset empties the pipeline and opens the input
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("pipeline not empty after reset");

    // input only closes once an output word has been held back
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && $past(m_valid && !m_ready)))
        else $error("s_ready low without an output stall");

    // held output word stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_mapped_value)))
        else $error("output word changed while stalled");

    // once the held output word drains, the input reopens
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_ready && m_ready) |=> s_ready)
        else $error("s_ready stuck after output drained");

endmodule

bind linear_range_map_deadband_unit lrmd_props u_lrmd_props (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_mapped_value (m_mapped_value)
);
